// ===== rtl/pfr_pkg.sv =====
// Package for the page frame replacement block: sizes, operation and
// register codes, request, response and frame table types.
// No dependencies.
package pfr_pkg;

	// Frame table size and page size (page size is a power of two)
	localparam int NUM_FRAMES = 16;
	localparam int PAGE_WORDS = 16;
	localparam int PAGE_SHIFT = $clog2(PAGE_WORDS);
	localparam int IDXW       = $clog2(NUM_FRAMES);
	localparam int CNTW       = IDXW + 1;

	// Field widths
	localparam int OWNER_W = 8;
	localparam int PAGE_W  = 12;
	localparam int TIME_W  = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd1;

	// Replacement policies
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	// Operation codes
	localparam logic [1:0] FUNC_FAULT   = 2'd0;
	localparam logic [1:0] FUNC_TOUCH   = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [OWNER_W-1:0] owner_id;
		logic [15:0]        address;
		logic [3:0]         frame_index;
		logic [TIME_W-1:0]  now;
	} req_t;

	typedef struct packed {
		logic [3:0]         chosen_frame;
		logic               evicted;
		logic [OWNER_W-1:0] evicted_owner;
		logic [PAGE_W-1:0]  evicted_page;
	} rsp_t;

	// One frame table entry as read from the store
	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [PAGE_W-1:0]  page;
		logic [TIME_W-1:0]  alloc_time;
		logic [TIME_W-1:0]  access_time;
	} entry_t;

	// Write controls toward the store
	typedef struct packed {
		logic            info_we;
		logic            access_we;
		logic [IDXW-1:0] addr;
		entry_t          data;
	} wr_t;

endpackage

// ===== rtl/page_frame_replacement.sv =====
// Page frame replacement: top level with request sequencer, frame scan and
// result register. Depends on pfr_pkg and pfr_store.
//
// Frame table for demand paging. A fault takes the lowest free managed frame
// without a scan; when every managed frame is allocated it reads the frame
// table one entry per cycle to find the oldest allocation (FIFO) or oldest
// access (LRU) among the managed frames (n_frames, held to 1..NUM_FRAMES).
// A release reads every frame's owner the same way. Touch and unused codes
// need no table read. The single read port of the frame table memory sets
// the pace of these reads. One request is in work at a time; the result
// register lets the next request in while a response waits, and a request
// that finishes while that register is still full holds in its final state
// until it drains.
module page_frame_replacement (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pfr_pkg::req_t                    req,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pfr_pkg::rsp_t                    rsp,
	input  logic                             cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam int IDXW = pfr_pkg::IDXW;
	localparam int CNTW = pfr_pkg::CNTW;

	logic [1:0]                        state_q;
	logic                              policy_q;
	logic [pfr_pkg::CFG_DATA_W-1:0]    frames_q;
	logic [pfr_pkg::NUM_FRAMES-1:0]    alloc_q;
	pfr_pkg::req_t                     req_q;
	logic [CNTW-1:0]                   cnt_q;
	logic [CNTW-1:0]                   lim_q;
	logic                              rd_vld_s1;
	logic [IDXW-1:0]                   idx_s1;
	logic [IDXW-1:0]                   best_idx_q;
	logic [pfr_pkg::TIME_W-1:0]        best_key_q;
	logic [pfr_pkg::OWNER_W-1:0]       best_owner_q;
	logic [pfr_pkg::PAGE_W-1:0]        best_page_q;
	logic                              evict_q;
	logic                              out_valid_q;
	pfr_pkg::rsp_t                     rsp_q;

	logic [CNTW-1:0]                   n_frames;
	logic                              free_found;
	logic [IDXW-1:0]                   free_idx;
	logic                              accept;
	logic                              issue;
	logic                              last;
	logic                              better;
	logic [pfr_pkg::TIME_W-1:0]        key;
	logic                              push;
	logic                              touch_ok;
	pfr_pkg::entry_t                   rd_data;
	pfr_pkg::wr_t                      wr;
	pfr_pkg::rsp_t                     rsp_d;

	// Clamp the managed frame count to 1..NUM_FRAMES
	always_comb begin
		if (frames_q == '0) begin
			n_frames = CNTW'(1);
		end else if (32'(frames_q) > pfr_pkg::NUM_FRAMES) begin
			n_frames = CNTW'(pfr_pkg::NUM_FRAMES);
		end else begin
			n_frames = CNTW'(frames_q);
		end
	end

	// Find the lowest free managed frame
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = pfr_pkg::NUM_FRAMES - 1; i >= 0; i--) begin
			if (!alloc_q[i] && (32'(i) < 32'(n_frames))) begin
				free_found = 1'b1;
				free_idx   = IDXW'(i);
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Table read sequencing, shared by victim scan and release sweep
	assign issue = ((state_q == ST_SCAN) || (state_q == ST_SWEEP)) && (cnt_q < lim_q);
	assign last  = rd_vld_s1 && (({1'b0, idx_s1} + CNTW'(1)) == lim_q);

	// Compare key of the returning entry against the best so far
	assign key    = (policy_q == pfr_pkg::POLICY_LRU) ? rd_data.access_time
		: rd_data.alloc_time;
	assign better = (idx_s1 == '0) || (key < best_key_q);

	// Hand the result over once the output register is free
	assign push     = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign touch_ok = (32'(req_q.frame_index) < 32'(n_frames));

	// Build the response
	always_comb begin
		rsp_d = '0;
		if (req_q.func == pfr_pkg::FUNC_FAULT) begin
			rsp_d.chosen_frame = 4'(best_idx_q);
			rsp_d.evicted      = evict_q;
			if (evict_q) begin
				rsp_d.evicted_owner = best_owner_q;
				rsp_d.evicted_page  = best_page_q;
			end
		end
	end

	// Table writes on completion
	always_comb begin
		wr                  = '0;
		wr.data.owner       = req_q.owner_id;
		wr.data.page        = pfr_pkg::PAGE_W'(req_q.address >> pfr_pkg::PAGE_SHIFT);
		wr.data.alloc_time  = req_q.now;
		wr.data.access_time = req_q.now;
		wr.addr             = best_idx_q;
		if (push) begin
			if (req_q.func == pfr_pkg::FUNC_FAULT) begin
				wr.info_we   = 1'b1;
				wr.access_we = 1'b1;
			end else if (req_q.func == pfr_pkg::FUNC_TOUCH && touch_ok) begin
				wr.access_we = 1'b1;
				wr.addr      = IDXW'(req_q.frame_index);
			end
		end
	end

	pfr_store u_store (
		.clk     (clk),
		.rd_en   (issue),
		.rd_addr (cnt_q[IDXW-1:0]),
		.rd_data (rd_data),
		.wr      (wr)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfr_pkg::POLICY_LRU;
			frames_q <= pfr_pkg::CFG_DATA_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				pfr_pkg::CFG_POLICY: policy_q <= cfg_data[0];
				pfr_pkg::CFG_FRAMES: frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request sequencer and allocation flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			alloc_q   <= '0;
			cnt_q     <= '0;
			lim_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.func == pfr_pkg::FUNC_FAULT) begin
							lim_q   <= n_frames;
							state_q <= free_found ? ST_FIN : ST_SCAN;
						end else if (req.func == pfr_pkg::FUNC_RELEASE) begin
							lim_q   <= CNTW'(pfr_pkg::NUM_FRAMES);
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= ST_FIN;
					end
				end
				ST_SWEEP: begin
					// drop frames of the released process
					if (rd_vld_s1 && alloc_q[idx_s1] && rd_data.owner == req_q.owner_id) begin
						alloc_q[idx_s1] <= 1'b0;
					end
					if (last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (push) begin
						if (req_q.func == pfr_pkg::FUNC_FAULT) begin
							alloc_q[best_idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request and track the victim candidate
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDXW-1:0];
		if (accept) begin
			req_q      <= req;
			best_idx_q <= free_idx;
			evict_q    <= !free_found;
		end
		if (state_q == ST_SCAN && rd_vld_s1 && better) begin
			best_idx_q   <= idx_s1;
			best_key_q   <= key;
			best_owner_q <= rd_data.owner;
			best_page_q  <= rd_data.page;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/pfr_store.sv =====
// Frame table store: owner, page and allocation time in one memory,
// last-access time in a second, both with registered reads.
// Depends on pfr_pkg.
module pfr_store (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [pfr_pkg::IDXW-1:0]   rd_addr,
	output pfr_pkg::entry_t            rd_data,
	input  pfr_pkg::wr_t               wr
);

	typedef struct packed {
		logic [pfr_pkg::OWNER_W-1:0] owner;
		logic [pfr_pkg::PAGE_W-1:0]  page;
		logic [pfr_pkg::TIME_W-1:0]  alloc_time;
	} info_t;

	info_t                       info_mem [pfr_pkg::NUM_FRAMES];
	logic [pfr_pkg::TIME_W-1:0]  acc_mem  [pfr_pkg::NUM_FRAMES];
	info_t                       info_rd_q;
	logic [pfr_pkg::TIME_W-1:0]  acc_rd_q;

	// Write ports
	always_ff @(posedge clk) begin
		if (wr.info_we) begin
			info_mem[wr.addr] <= '{owner: wr.data.owner, page: wr.data.page,
				alloc_time: wr.data.alloc_time};
		end
		if (wr.access_we) begin
			acc_mem[wr.addr] <= wr.data.access_time;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			info_rd_q <= info_mem[rd_addr];
			acc_rd_q  <= acc_mem[rd_addr];
		end
	end

	assign rd_data = '{owner: info_rd_q.owner, page: info_rd_q.page,
		alloc_time: info_rd_q.alloc_time, access_time: acc_rd_q};

endmodule
